@@ hw/rtl/multiply_divide_64_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the multiply-then-divide unit
// Short wrappers so that the checks at the end of the module stay one line.
// ---------------------------------------------------------------------------
`ifndef MULTIPLY_DIVIDE_64_UNIT_MACROS_SVH
`define MULTIPLY_DIVIDE_64_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MDU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MDU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/mdu_pkg.sv @@
// ---------------------------------------------------------------------------
// Multiply-then-divide unit package
// Field widths and bus packing constants shared by the unit and its ports.
// ---------------------------------------------------------------------------
package mdu_pkg;

  // Width of every operand and result field on the bus
  localparam int FIELD_W = 64;

  // Default arithmetic width inside the unit
  localparam int DATA_WIDTH_DEF = 64;

  // Input tdata: operand, multiplier, divisor
  localparam int IN_TDATA_W = 3 * FIELD_W;

  // Output tdata: quotient
  localparam int OUT_TDATA_W = FIELD_W;

endpackage

@@ hw/rtl/multiply_divide_64_unit.sv @@
// ---------------------------------------------------------------------------
// Multiply-then-divide unit
// Returns floor(operand * multiplier / divisor) from the full double-width
// product, truncated to DATA_WIDTH bits; a zero divisor gives zero and a flag.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one transaction carries operand, multiplier and
//   divisor. in_tready is high only while the unit is idle; it drops as soon
//   as a transaction is taken and stays low until the result has been taken.
//   Output channel out_*: one transaction per input, quotient in out_tdata,
//   zero-divisor flag in out_tuser.
//   Timing: one shared adder does all the work. The product is built by
//   shift-and-add, then restoring division runs one quotient bit per
//   cycle. A zero divisor skips the arithmetic and gives its result in the
//   cycle after acceptance. Items do not overlap: a new item is taken only
//   once the previous result has been taken.
//   Reset: synchronous, active low; returns the sequencer to idle and drops
//   out_tvalid. No state survives between items.
//   Stall: the result holds in the output register while out_tready is low,
//   and no new input is taken until it has gone.
// ---------------------------------------------------------------------------
module multiply_divide_64_unit #(
  parameter int DATA_WIDTH = mdu_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [63:0] operand, [127:64] multiplier, [191:128] divisor
  input  logic [mdu_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [63:0] quotient
  output logic [mdu_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] zero_divisor
  output logic                             out_tuser
);

  import mdu_pkg::*;

  `include "multiply_divide_64_unit_macros.svh"

  localparam int W     = DATA_WIDTH;
  localparam int CNT_W = $clog2(2 * W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [W-1:0]       a_r;      // multiplicand
  logic [W-1:0]       d_r;      // divisor
  logic [W-1:0]       h_r;      // high half of product / dividend
  logic [W-1:0]       l_r;      // multiplier, low half, then quotient
  logic [W-1:0]       rem_r;
  logic [FIELD_W-1:0] q_out_r;
  logic               zdiv_r;

  logic [W:0]         add_a;
  logic [W:0]         add_b;
  logic               add_cin;
  logic [W+1:0]       sum;
  logic               ge;

  logic [W-1:0]       in_operand;
  logic [W-1:0]       in_multiplier;
  logic [W-1:0]       in_divisor;

  assign in_operand    = in_tdata[W-1:0];
  assign in_multiplier = in_tdata[FIELD_W+W-1:FIELD_W];
  assign in_divisor    = in_tdata[2*FIELD_W+W-1:2*FIELD_W];

  // Shared adder: accumulate in the multiply phase, trial subtract in divide
  always_comb begin
    case (state_r)
      ST_MUL: begin
        add_a   = {1'b0, h_r};
        add_b   = l_r[0] ? {1'b0, a_r} : '0;
        add_cin = 1'b0;
      end
      ST_DIV: begin
        add_a   = {rem_r, h_r[W-1]};
        add_b   = ~{1'b0, d_r};
        add_cin = 1'b1;
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
      end
    endcase
  end

  assign sum = {1'b0, add_a} + {1'b0, add_b} + (W+2)'(add_cin);
  // carry out of the subtract: shifted remainder not below divisor
  assign ge  = sum[W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            a_r   <= in_operand;
            d_r   <= in_divisor;
            l_r   <= in_multiplier;
            h_r   <= '0;
            rem_r <= '0;
            cnt_r <= '0;
            if (in_divisor == '0) begin
              q_out_r <= '0;
              zdiv_r  <= 1'b1;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          // shift the running sum right into the multiplier register
          h_r <= sum[W:1];
          l_r <= {sum[0], l_r[W-1:1]};
          if (cnt_r == CNT_W'(W - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DIV: begin
          // advance the dividend left, shift the quotient bit in at the bottom
          rem_r <= ge ? sum[W-1:0] : add_a[W-1:0];
          h_r   <= {h_r[W-2:0], l_r[W-1]};
          l_r   <= {l_r[W-2:0], ge};
          if (cnt_r == CNT_W'(2 * W - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_DONE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_tready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      // capture the quotient on the last divide step
      if (state_r == ST_DIV && cnt_r == CNT_W'(2 * W - 1)) begin
        q_out_r <= FIELD_W'({l_r[W-2:0], ge});
        zdiv_r  <= 1'b0;
      end
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_DONE);
  assign out_tdata  = q_out_r;
  assign out_tuser  = zdiv_r;

  `MDU_ASSERT_NOW(a_busy_not_ready, out_tvalid, !in_tready, "input taken while result pending")
  `MDU_ASSERT_NOW(a_zdiv_zero, out_tvalid && out_tuser, out_tdata == '0,
                  "zero divisor, non-zero quotient")
  `MDU_ASSERT_NEXT(a_zdiv_fast, in_tvalid && in_tready && in_divisor == '0,
                   out_tvalid && out_tuser, "zero divisor result late")
  `MDU_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, !in_tready, "ready held after accept")
  `MDU_ASSERT_NOW(a_div_nonzero, state_r == ST_DIV, d_r != '0 && rem_r < d_r,
                  "remainder out of range")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Multiply-then-divide unit testbench
// Drives operand/multiplier/divisor transactions into the unit with random
// gaps and output back-pressure, predicts floor(a*b/c) from the full 128-bit
// product, and compares every result transaction against it in order.
// ---------------------------------------------------------------------------

typedef logic [mdu_pkg::FIELD_W-1:0] word_t;

typedef struct packed {
  word_t quotient;
  logic  zero_divisor;
} scaled_result_t;

class quotient_ledger;
  scaled_result_t pending[$];
  int unsigned    mismatches;

  function new();
    mismatches = 0;
  endfunction

  // Scale a by b/c with the double-width product; truncate to the field width
  function scaled_result_t scale(word_t operand, word_t multiplier, word_t divisor);
    logic [2*mdu_pkg::FIELD_W-1:0] wide;
    scaled_result_t r;
    if (divisor == '0) begin
      r.quotient     = '0;
      r.zero_divisor = 1'b1;
    end else begin
      wide           = {{mdu_pkg::FIELD_W{1'b0}}, operand} *
                       {{mdu_pkg::FIELD_W{1'b0}}, multiplier};
      wide           = wide / {{mdu_pkg::FIELD_W{1'b0}}, divisor};
      r.quotient     = wide[mdu_pkg::FIELD_W-1:0];
      r.zero_divisor = 1'b0;
    end
    return r;
  endfunction

  function void note_item(word_t operand, word_t multiplier, word_t divisor);
    pending.push_back(scale(operand, multiplier, divisor));
  endfunction

  function void check_result(word_t quotient, logic zero_divisor);
    scaled_result_t want;
    if (pending.size() == 0) begin
      $error("result transaction with nothing outstanding: quotient %h", quotient);
      mismatches++;
      return;
    end
    want = pending.pop_front();
    if (quotient !== want.quotient) begin
      $error("quotient: expected %h, actual %h", want.quotient, quotient);
      mismatches++;
    end
    if (zero_divisor !== want.zero_divisor) begin
      $error("zero_divisor: expected %b, actual %b", want.zero_divisor, zero_divisor);
      mismatches++;
    end
  endfunction

  function bit drained();
    return pending.size() == 0;
  endfunction
endclass

module testbench;
  localparam int    ITEM_COUNT = 1750;
  localparam word_t ALL_ONES   = '1;
  localparam word_t TOP_BIT    = 64'h8000_0000_0000_0000;
  localparam word_t ALT_HI     = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam word_t ALT_LO     = 64'h5555_5555_5555_5555;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic [mdu_pkg::IN_TDATA_W-1:0] in_tdata   = '0;
  logic                           out_tready = 1'b0;
  logic                           in_tready;
  logic                           out_tvalid;
  logic [mdu_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                           out_tuser;

  quotient_ledger ledger;
  bit             steady = 1'b0;

  multiply_divide_64_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_ONES - $urandom_range(0, 3);
      2:       return word_t'($urandom_range(0, 255));
      3:       return word_t'(1) << $urandom_range(0, mdu_pkg::FIELD_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Leave in_tvalid high after the transaction; the next call decides
  task automatic send_item(word_t operand, word_t multiplier, word_t divisor);
    int gap;
    gap = steady ? 0 : idle_length();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {divisor, multiplier, operand};
    do @(posedge clk); while (!in_tready);
    ledger.note_item(operand, multiplier, divisor);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (!ledger.drained());
  endtask

  initial begin : stimulus
    word_t                         a, b, c;
    logic [2*mdu_pkg::FIELD_W-1:0] wide;
    ledger = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_item('0, '0, word_t'(1));
    send_item(ALL_ONES, ALL_ONES, word_t'(1));      // quotient wraps
    send_item(ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(ALL_ONES, ALL_ONES, ALL_ONES - 1);     // remainder top bit in play
    send_item(ALL_ONES, ALL_ONES, TOP_BIT);
    send_item(ALL_ONES, word_t'(1), word_t'(1));
    send_item(word_t'(1), word_t'(1), ALL_ONES);
    send_item(ALL_ONES, ALL_ONES, '0);               // zero divisor
    send_item('0, '0, '0);
    send_item('0, ALL_ONES, word_t'(7));
    send_item(ALL_ONES, '0, word_t'(7));
    send_item(TOP_BIT, word_t'(4), word_t'(1));
    send_item(word_t'(1) << 32, word_t'(1) << 32, word_t'(1));
    send_item(word_t'(1) << 32, word_t'(1) << 32, word_t'(2));
    send_item(ALT_HI, ALT_LO, word_t'(3));
    send_item(ALT_LO, ALT_HI, ALT_HI);
    send_item(word_t'(123456789), word_t'(987654321), word_t'(1000));
    send_item(ALL_ONES, word_t'(2), word_t'(2));
    send_item(ALT_HI, ALL_ONES, ALT_LO);
    send_item({$urandom, $urandom}, {$urandom, $urandom}, '0);

    // Hold off until the directed results are all back
    in_tvalid <= 1'b0;
    wait_drained();

    for (int n = 0; n < ITEM_COUNT; n++) begin
      steady = (n % 500) >= 400;
      if (n == 900) begin
        in_tvalid <= 1'b0;
        wait_drained();
      end
      a = random_word();
      b = random_word();
      case ($urandom_range(0, 19))
        0:             c = '0;
        1, 2:          c = word_t'($urandom_range(1, 16));
        3, 4, 5, 6, 7: begin
          // Divisor just above the high half keeps the quotient in range
          wide = {{mdu_pkg::FIELD_W{1'b0}}, a} * {{mdu_pkg::FIELD_W{1'b0}}, b};
          c    = wide[2*mdu_pkg::FIELD_W-1:mdu_pkg::FIELD_W] + $urandom_range(1, 1000);
        end
        default:       c = random_word();
      endcase
      send_item(a, b, c);
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.drained()) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    stall = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        ledger.check_result(out_tdata, out_tuser);
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) begin
          stall = idle_length();
        end
      end
    end
  end

  initial begin : watchdog
    #25_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
